### src/ipv4_header_check_and_stats_top_defines.svh
// ----------------------------------------------------------------------------
// ipv4 header check and stats: assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_CHECK_AND_STATS_TOP_DEFINES_SVH
`define IPV4_HEADER_CHECK_AND_STATS_TOP_DEFINES_SVH

// same-cycle implication
`define IHCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihcs assertion failed");

// next-cycle implication
`define IHCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihcs assertion failed");

`endif

### src/ihcs_pkg.sv
// ----------------------------------------------------------------------------
// ihcs_pkg
// shared constants, types and helper functions of the ipv4 header check
// ----------------------------------------------------------------------------
package ihcs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);
  localparam logic [FILL_W-1:0] FILL_ONE   = FILL_W'(1);

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [3:0]  IP_VERSION_4  = 4'd4;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [12:0] OFFSET_MASK   = 13'h1FFF;

  localparam logic [7:0] OCT_PRIV_A   = 8'd10;
  localparam logic [7:0] OCT_PRIV_B   = 8'd172;
  localparam logic [7:0] OCT_PRIV_C   = 8'd192;
  localparam logic [7:0] OCT_PRIV_C2  = 8'd168;
  localparam logic [7:0] OCT_PRIV_BLO = 8'd16;
  localparam logic [7:0] OCT_PRIV_BHI = 8'd31;
  localparam logic [7:0] OCT_MC_LO    = 8'd224;
  localparam logic [7:0] OCT_MC_HI    = 8'd239;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_VERSION = 2'd2,
    ST_HDRLEN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PSEL_TCP   = 2'd0,
    PSEL_UDP   = 2'd1,
    PSEL_ICMP  = 2'd2,
    PSEL_OTHER = 2'd3
  } proto_sel_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic              rd_en;
    logic [FILL_W-1:0] rd_idx;
    logic              commit;
  } tbl_ctrl_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              found;
  } tbl_stat_t;

  typedef struct packed {
    logic       clear;
    logic       commit;
    proto_sel_t proto_sel;
    logic       frag;
    logic       opts;
    logic [15:0] tlen;
  } stats_ctrl_t;

  typedef struct packed {
    logic [31:0] packet;
    logic [47:0] bytes;
    logic [31:0] tcp;
    logic [31:0] udp;
    logic [31:0] icmp;
    logic [31:0] other;
    logic [31:0] frag;
    logic [31:0] opts;
  } counters_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    return (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic addr_private(input logic [31:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    o1 = a[31:24];
    o2 = a[23:16];
    return (o1 == OCT_PRIV_A) ||
           (o1 == OCT_PRIV_B && (o2 inside {[OCT_PRIV_BLO:OCT_PRIV_BHI]})) ||
           (o1 == OCT_PRIV_C && o2 == OCT_PRIV_C2);
  endfunction

  function automatic logic addr_multicast(input logic [31:0] a);
    return a[31:24] inside {[OCT_MC_LO:OCT_MC_HI]};
  endfunction

endpackage

### src/ihcs_in_if.sv
// ----------------------------------------------------------------------------
// ihcs_in_if
// input channel: one decoded ipv4 header per transfer
// ----------------------------------------------------------------------------
interface ihcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] captured_length;
  logic [3:0]  ip_version;
  logic [3:0]  header_words;
  logic [15:0] ip_total_len;
  logic [15:0] flags_and_offset;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic        clear_stats;

  modport source (
    output valid, captured_length, ip_version, header_words, ip_total_len,
           flags_and_offset, protocol_number, source_address, dest_address,
           clear_stats,
    input  ready
  );

  modport sink (
    input  valid, captured_length, ip_version, header_words, ip_total_len,
           flags_and_offset, protocol_number, source_address, dest_address,
           clear_stats,
    output ready
  );
endinterface

### src/ihcs_out_if.sv
// ----------------------------------------------------------------------------
// ihcs_out_if
// result channel: status, counters and address class per transfer
// ----------------------------------------------------------------------------
interface ihcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [31:0]               packet_total;
  logic [47:0]               byte_total;
  logic [31:0]               tcp_total;
  logic [31:0]               udp_total;
  logic [31:0]               icmp_total;
  logic [31:0]               other_total;
  logic [31:0]               fragment_total;
  logic [31:0]               options_total;
  logic [ihcs_pkg::FILL_W-1:0] unique_sources;
  logic [ihcs_pkg::FILL_W-1:0] unique_dests;
  logic [3:0]                address_class;

  modport source (
    output valid, status, packet_total, byte_total, tcp_total, udp_total,
           icmp_total, other_total, fragment_total, options_total,
           unique_sources, unique_dests, address_class,
    input  ready
  );

  modport sink (
    input  valid, status, packet_total, byte_total, tcp_total, udp_total,
           icmp_total, other_total, fragment_total, options_total,
           unique_sources, unique_dests, address_class,
    output ready
  );
endinterface

### src/ipv4_header_check_and_stats_top.sv
// ----------------------------------------------------------------------------
// ipv4_header_check_and_stats_top
// ipv4 header validation with traffic counters and address tables
//
// in_chan carries one decoded header per transfer, out_chan one result per
// header: status, all counters, table fill counts and the address class.
// Both channels use valid/ready; a transfer happens when both are high.
// A rejected header goes from the transfer straight to the result register,
// and the next header can be taken once that result is loaded. An accepted
// header scans the source and destination tables side by side, one entry
// per cycle through each single-port ram, then writes any new address back;
// the scan covers the larger of the two fill counts (at most 256), and the
// next header can be taken in the cycle its result comes out. One header is
// in work at a time. The result is held in an output register, so the next
// header is taken while a result still waits; a stalled receiver holds the
// block before the result register is reloaded. Synchronous reset zeroes
// counters and fill counts; table contents need no clearing. clear_stats
// does the same at the start of its own header.
// ----------------------------------------------------------------------------
`include "ipv4_header_check_and_stats_top_defines.svh"

module ipv4_header_check_and_stats_top (
  input  logic              clk,
  input  logic              rst_n,
  ihcs_in_if.sink           in_chan,
  ihcs_out_if.source        out_chan
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic                   in_fire;
  logic [15:0]            hbytes;
  ihcs_pkg::status_t      status_in;
  ihcs_pkg::proto_sel_t   psel_in;

  ihcs_pkg::status_t      status_r;
  ihcs_pkg::proto_sel_t   psel_r;
  logic                   frag_r;
  logic                   opts_r;
  logic [15:0]            tlen_r;
  logic [31:0]            src_r;
  logic [31:0]            dst_r;
  logic [3:0]             cls_r;

  logic [ihcs_pkg::FILL_W-1:0] rd_idx_r;
  logic                        pend_r;
  logic [ihcs_pkg::FILL_W-1:0] max_fill;
  logic                        issue;
  logic                        rd_en;

  ihcs_pkg::tbl_ctrl_t    src_ctrl, dst_ctrl;
  ihcs_pkg::tbl_stat_t    src_stat, dst_stat;
  ihcs_pkg::stats_ctrl_t  st_ctrl;
  ihcs_pkg::counters_t    cnt;

  logic                   out_valid_r;
  logic                   out_load;

  // header checks
  assign hbytes = {10'd0, in_chan.header_words, 2'b00};

  always_comb begin
    if (in_chan.captured_length < ihcs_pkg::MIN_HDR_BYTES) begin
      status_in = ihcs_pkg::ST_SHORT;
    end else if (in_chan.ip_version != ihcs_pkg::IP_VERSION_4) begin
      status_in = ihcs_pkg::ST_VERSION;
    end else if (hbytes < ihcs_pkg::MIN_HDR_BYTES || hbytes > in_chan.captured_length) begin
      status_in = ihcs_pkg::ST_HDRLEN;
    end else begin
      status_in = ihcs_pkg::ST_OK;
    end
  end

  always_comb begin
    case (in_chan.protocol_number)
      ihcs_pkg::PROTO_TCP:  psel_in = ihcs_pkg::PSEL_TCP;
      ihcs_pkg::PROTO_UDP:  psel_in = ihcs_pkg::PSEL_UDP;
      ihcs_pkg::PROTO_ICMP: psel_in = ihcs_pkg::PSEL_ICMP;
      default:              psel_in = ihcs_pkg::PSEL_OTHER;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  // scan sequencing
  assign max_fill = (src_stat.fill > dst_stat.fill) ? src_stat.fill : dst_stat.fill;
  assign issue    = rd_idx_r < max_fill;
  assign rd_en    = (state_r == S_SCAN) && issue;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (status_in == ihcs_pkg::ST_OK) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (in_fire) begin
        rd_idx_r <= '0;
      end else if (rd_en) begin
        rd_idx_r <= rd_idx_r + ihcs_pkg::FILL_ONE;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_in;
      psel_r   <= psel_in;
      frag_r   <= ((in_chan.flags_and_offset[12:0] & ihcs_pkg::OFFSET_MASK) != 13'd0) ||
                  in_chan.flags_and_offset[13];
      opts_r   <= hbytes > ihcs_pkg::MIN_HDR_BYTES;
      tlen_r   <= in_chan.ip_total_len;
      src_r    <= in_chan.source_address;
      dst_r    <= in_chan.dest_address;
      cls_r    <= {ihcs_pkg::addr_multicast(in_chan.dest_address),
                   ihcs_pkg::addr_private(in_chan.dest_address),
                   ihcs_pkg::addr_multicast(in_chan.source_address),
                   ihcs_pkg::addr_private(in_chan.source_address)};
    end
  end

  // tables and counters
  assign src_ctrl.start  = in_fire;
  assign src_ctrl.clear  = in_fire && in_chan.clear_stats;
  assign src_ctrl.rd_en  = rd_en;
  assign src_ctrl.rd_idx = rd_idx_r;
  assign src_ctrl.commit = (state_r == S_COMMIT);
  assign dst_ctrl        = src_ctrl;

  ihcs_table u_src_table (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (src_r),
    .ctrl  (src_ctrl),
    .stat  (src_stat)
  );

  ihcs_table u_dst_table (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (dst_r),
    .ctrl  (dst_ctrl),
    .stat  (dst_stat)
  );

  assign st_ctrl.clear     = in_fire && in_chan.clear_stats;
  assign st_ctrl.commit    = (state_r == S_COMMIT);
  assign st_ctrl.proto_sel = psel_r;
  assign st_ctrl.frag      = frag_r;
  assign st_ctrl.opts      = opts_r;
  assign st_ctrl.tlen      = tlen_r;

  ihcs_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (st_ctrl),
    .cnt   (cnt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan.status         <= status_r;
      out_chan.packet_total   <= cnt.packet;
      out_chan.byte_total     <= cnt.bytes;
      out_chan.tcp_total      <= cnt.tcp;
      out_chan.udp_total      <= cnt.udp;
      out_chan.icmp_total     <= cnt.icmp;
      out_chan.other_total    <= cnt.other;
      out_chan.fragment_total <= cnt.frag;
      out_chan.options_total  <= cnt.opts;
      out_chan.unique_sources <= src_stat.fill;
      out_chan.unique_dests   <= dst_stat.fill;
      out_chan.address_class  <= cls_r;
    end
  end

  assign out_chan.valid = out_valid_r;

  `IHCS_ASSERT_NEXT(a_reject_to_done, in_fire && (status_in != ihcs_pkg::ST_OK), state_r == S_DONE)
  `IHCS_ASSERT_NOW(a_commit_ok, state_r == S_COMMIT, status_r == ihcs_pkg::ST_OK)
  `IHCS_ASSERT_NOW(a_fill_bound, 1'b1, src_stat.fill <= ihcs_pkg::DEPTH_FILL && dst_stat.fill <= ihcs_pkg::DEPTH_FILL)
  `IHCS_ASSERT_NOW(a_scan_bound, rd_en, rd_idx_r < ihcs_pkg::DEPTH_FILL)

endmodule

### src/ihcs_ram.sv
// ----------------------------------------------------------------------------
// ihcs_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module ihcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/ihcs_table.sv
// ----------------------------------------------------------------------------
// ihcs_table
// address table: ram, fill count and match flag for one scan
// ----------------------------------------------------------------------------
module ihcs_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         key,
  input  ihcs_pkg::tbl_ctrl_t ctrl,
  output ihcs_pkg::tbl_stat_t stat
);

  logic [ihcs_pkg::FILL_W-1:0] fill_r;
  logic                        found_r;
  logic                        pend_r;
  logic [ihcs_pkg::FILL_W-1:0] cmp_idx_r;
  logic [31:0]                 rdata;
  logic                        we;
  logic [ihcs_pkg::IDX_W-1:0]  addr;

  assign we   = ctrl.commit && !found_r && (fill_r < ihcs_pkg::DEPTH_FILL);
  assign addr = ctrl.commit ? fill_r[ihcs_pkg::IDX_W-1:0]
                            : ctrl.rd_idx[ihcs_pkg::IDX_W-1:0];

  ihcs_ram #(
    .WIDTH (32),
    .DEPTH (ihcs_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (key),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      found_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= ctrl.rd_en;
      if (ctrl.clear) begin
        fill_r <= '0;
      end else if (we) begin
        fill_r <= fill_r + ihcs_pkg::FILL_ONE;
      end
      if (ctrl.start) begin
        found_r <= 1'b0;
      end else if (pend_r && (cmp_idx_r < fill_r) && (rdata == key)) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= ctrl.rd_idx;
  end

  assign stat.fill  = fill_r;
  assign stat.found = found_r;

endmodule

### src/ihcs_stats.sv
// ----------------------------------------------------------------------------
// ihcs_stats
// saturating traffic counters, updated once per accepted packet
// ----------------------------------------------------------------------------
module ihcs_stats (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ihcs_pkg::stats_ctrl_t ctrl,
  output ihcs_pkg::counters_t   cnt
);

  logic [31:0] packet_r;
  logic [47:0] bytes_r;
  logic [31:0] proto_r [4];
  logic [31:0] frag_r;
  logic [31:0] opts_r;
  logic [48:0] byte_sum;

  assign byte_sum = {1'b0, bytes_r} + {33'd0, ctrl.tlen};

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      packet_r <= '0;
      bytes_r  <= '0;
      frag_r   <= '0;
      opts_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        proto_r[i] <= '0;
      end
    end else if (ctrl.commit) begin
      packet_r <= ihcs_pkg::sat_inc32(packet_r);
      bytes_r  <= byte_sum[48] ? ihcs_pkg::MAX48 : byte_sum[47:0];
      proto_r[ctrl.proto_sel] <= ihcs_pkg::sat_inc32(proto_r[ctrl.proto_sel]);
      if (ctrl.frag) begin
        frag_r <= ihcs_pkg::sat_inc32(frag_r);
      end
      if (ctrl.opts) begin
        opts_r <= ihcs_pkg::sat_inc32(opts_r);
      end
    end
  end

  assign cnt.packet = packet_r;
  assign cnt.bytes  = bytes_r;
  assign cnt.tcp    = proto_r[ihcs_pkg::PSEL_TCP];
  assign cnt.udp    = proto_r[ihcs_pkg::PSEL_UDP];
  assign cnt.icmp   = proto_r[ihcs_pkg::PSEL_ICMP];
  assign cnt.other  = proto_r[ihcs_pkg::PSEL_OTHER];
  assign cnt.frag   = frag_r;
  assign cnt.opts   = opts_r;

endmodule

### verif/ihcs_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihcs_report_checker
// watches both channels of the ipv4 header check, keeps its own copy of the
// counters and address tables, works out the report for every header taken
// and compares it field by field with the report that comes out
// ----------------------------------------------------------------------------
module ihcs_report_checker (
  input  logic clk,
  input  logic rst_n,
  ihcs_in_if   in_mon,
  ihcs_out_if  out_mon,
  output int   mismatch_count,
  output int   pending_count
);
  import ihcs_pkg::*;

  localparam int MF_BIT = 13;

  typedef struct packed {
    status_t           status;
    counters_t         totals;
    logic [FILL_W-1:0] src_fill;
    logic [FILL_W-1:0] dst_fill;
    logic [3:0]        cls;
  } report_t;

  report_t     awaited_reports[$];
  counters_t   tally;
  logic [31:0] src_seen[$];
  logic [31:0] dst_seen[$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    tally          = '0;
  end

  function automatic logic [31:0] bump32(input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, v} + 33'd1;
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic is_private(input logic [31:0] a);
    if (a[31:24] == OCT_PRIV_A) return 1'b1;
    if (a[31:24] == OCT_PRIV_B && a[23:16] >= OCT_PRIV_BLO && a[23:16] <= OCT_PRIV_BHI)
      return 1'b1;
    return a[31:24] == OCT_PRIV_C && a[23:16] == OCT_PRIV_C2;
  endfunction

  function automatic logic is_multicast(input logic [31:0] a);
    return a[31:24] >= OCT_MC_LO && a[31:24] <= OCT_MC_HI;
  endfunction

  function automatic bit listed(input logic [31:0] seen[$], input logic [31:0] a);
    foreach (seen[i]) begin
      if (seen[i] == a) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic tally_header();
    report_t     r;
    logic [15:0] hbytes;
    logic [48:0] bsum;
    if (in_mon.clear_stats) begin
      tally = '0;
      src_seen.delete();
      dst_seen.delete();
    end
    hbytes = {10'd0, in_mon.header_words, 2'b00};
    if (in_mon.captured_length < MIN_HDR_BYTES) begin
      r.status = ST_SHORT;
    end else if (in_mon.ip_version != IP_VERSION_4) begin
      r.status = ST_VERSION;
    end else if (hbytes < MIN_HDR_BYTES || hbytes > in_mon.captured_length) begin
      r.status = ST_HDRLEN;
    end else begin
      r.status = ST_OK;
    end
    if (r.status == ST_OK) begin
      tally.packet = bump32(tally.packet);
      bsum = {1'b0, tally.bytes} + {33'd0, in_mon.ip_total_len};
      tally.bytes = bsum[48] ? MAX48 : bsum[47:0];
      case (in_mon.protocol_number)
        PROTO_TCP:  tally.tcp  = bump32(tally.tcp);
        PROTO_UDP:  tally.udp  = bump32(tally.udp);
        PROTO_ICMP: tally.icmp = bump32(tally.icmp);
        default:    tally.other = bump32(tally.other);
      endcase
      if ((in_mon.flags_and_offset[12:0] & OFFSET_MASK) != '0 ||
          in_mon.flags_and_offset[MF_BIT])
        tally.frag = bump32(tally.frag);
      if (hbytes > MIN_HDR_BYTES) tally.opts = bump32(tally.opts);
      if (!listed(src_seen, in_mon.source_address) && src_seen.size() < TABLE_DEPTH)
        src_seen.push_back(in_mon.source_address);
      if (!listed(dst_seen, in_mon.dest_address) && dst_seen.size() < TABLE_DEPTH)
        dst_seen.push_back(in_mon.dest_address);
    end
    r.totals   = tally;
    r.src_fill = FILL_W'(src_seen.size());
    r.dst_fill = FILL_W'(dst_seen.size());
    r.cls      = {is_multicast(in_mon.dest_address), is_private(in_mon.dest_address),
                  is_multicast(in_mon.source_address), is_private(in_mon.source_address)};
    awaited_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("checker: %s mismatch, expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic compare_report();
    report_t want;
    if (awaited_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("checker: report with nothing awaited");
      return;
    end
    want = awaited_reports.pop_front();
    check_field("status", want.status, out_mon.status);
    check_field("packet_total", want.totals.packet, out_mon.packet_total);
    check_field("byte_total", want.totals.bytes, out_mon.byte_total);
    check_field("tcp_total", want.totals.tcp, out_mon.tcp_total);
    check_field("udp_total", want.totals.udp, out_mon.udp_total);
    check_field("icmp_total", want.totals.icmp, out_mon.icmp_total);
    check_field("other_total", want.totals.other, out_mon.other_total);
    check_field("fragment_total", want.totals.frag, out_mon.fragment_total);
    check_field("options_total", want.totals.opts, out_mon.options_total);
    check_field("unique_sources", want.src_fill, out_mon.unique_sources);
    check_field("unique_dests", want.dst_fill, out_mon.unique_dests);
    check_field("address_class", want.cls, out_mon.address_class);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tally = '0;
      src_seen.delete();
      dst_seen.delete();
      awaited_reports.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) compare_report();
      if (in_mon.valid && in_mon.ready) tally_header();
    end
    pending_count = awaited_reports.size();
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives decoded ipv4 headers into the header check: a directed set over
// the check order, boundaries, protocols and address classes, then random
// phases with sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb;
  import ihcs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [15:0] captured_length;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] ip_total_len;
    logic [15:0] flags_and_offset;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        clear_stats;
  } hdr_t;

  logic clk;
  logic rst_n;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   hold_req  = 0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   pending_count;

  ihcs_in_if  in_chan ();
  ihcs_out_if out_chan ();

  ipv4_header_check_and_stats_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ihcs_report_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial out_chan.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic hdr_t mk(input int cap, input int ver, input int hw, input int tlen,
                              input int fo, input logic [7:0] proto,
                              input logic [31:0] src, input logic [31:0] dst,
                              input bit clr);
    hdr_t h;
    h.captured_length  = 16'(cap);
    h.ip_version       = 4'(ver);
    h.header_words     = 4'(hw);
    h.ip_total_len     = 16'(tlen);
    h.flags_and_offset = 16'(fo);
    h.protocol_number  = proto;
    h.source_address   = src;
    h.dest_address     = dst;
    h.clear_stats      = clr;
    return h;
  endfunction

  function automatic logic [31:0] pick_addr(input int fresh_pct);
    if ($urandom_range(99) >= fresh_pct) begin
      case ($urandom_range(7))
        0:       return 32'h0A01_0203;
        1:       return 32'hAC10_0001;
        2:       return 32'hC0A8_0101;
        3:       return 32'hE000_00FB;
        4:       return 32'h0808_0808;
        5:       return 32'hAC20_0001;
        6:       return 32'hEF00_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    case ($urandom_range(5))
      0:       return {OCT_PRIV_A, 24'($urandom)};
      1:       return {OCT_PRIV_B, 8'($urandom_range(12, 35)), 16'($urandom)};
      2:       return {OCT_PRIV_C, 8'($urandom_range(166, 170)), 16'($urandom)};
      3:       return {8'($urandom_range(220, 243)), 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic hdr_t gen_header(input int ok_pct, input int fresh_pct,
                                      input bit allow_clear);
    hdr_t h;
    int   kind;
    int   lo;
    int   v;
    kind = $urandom_range(99);
    h.ip_total_len = 16'($urandom);
    case ($urandom_range(4))
      0, 1:    h.flags_and_offset = 16'd0;
      2:       h.flags_and_offset = 16'h4000;
      default: h.flags_and_offset = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       h.protocol_number = PROTO_TCP;
      1:       h.protocol_number = PROTO_UDP;
      2:       h.protocol_number = PROTO_ICMP;
      default: h.protocol_number = 8'($urandom);
    endcase
    h.source_address = pick_addr(fresh_pct);
    h.dest_address   = pick_addr(fresh_pct);
    h.clear_stats    = allow_clear && ($urandom_range(99) == 0);
    h.ip_version     = IP_VERSION_4;
    if (kind < ok_pct) begin
      h.header_words = ($urandom_range(1) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
      lo = 4 * int'(h.header_words);
      h.captured_length = ($urandom_range(1) != 0) ? 16'(lo + $urandom_range(0, 64))
                                                   : 16'($urandom_range(lo, 65535));
    end else if (kind < ok_pct + (100 - ok_pct) * 2 / 3) begin
      h.header_words = 4'($urandom);
      case ($urandom_range(2))
        0: begin
          h.captured_length = 16'($urandom_range(0, 19));
          h.ip_version = 4'($urandom);
        end
        1: begin
          h.captured_length = 16'($urandom_range(20, 65535));
          v = $urandom_range(0, 14);
          if (v >= 4) v++;
          h.ip_version = 4'(v);
        end
        default: begin
          if ($urandom_range(1) != 0) begin
            h.header_words = 4'($urandom_range(0, 4));
            h.captured_length = 16'($urandom_range(20, 65535));
          end else begin
            lo = $urandom_range(20, 56);
            h.captured_length = 16'(lo);
            h.header_words = 4'($urandom_range(lo / 4 + 1, 15));
          end
        end
      endcase
    end else begin
      h.captured_length  = 16'($urandom);
      h.ip_version       = 4'($urandom);
      h.header_words     = 4'($urandom);
      h.flags_and_offset = 16'($urandom);
      h.protocol_number  = 8'($urandom);
      h.source_address   = $urandom;
      h.dest_address     = $urandom;
      h.clear_stats      = allow_clear && ($urandom_range(1) != 0);
    end
    return h;
  endfunction

  task automatic send_header(input hdr_t h);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.captured_length  <= h.captured_length;
    in_chan.ip_version       <= h.ip_version;
    in_chan.header_words     <= h.header_words;
    in_chan.ip_total_len     <= h.ip_total_len;
    in_chan.flags_and_offset <= h.flags_and_offset;
    in_chan.protocol_number  <= h.protocol_number;
    in_chan.source_address   <= h.source_address;
    in_chan.dest_address     <= h.dest_address;
    in_chan.clear_stats      <= h.clear_stats;
    in_chan.valid            <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  initial begin
    int n_items;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.captured_length  <= '0;
    in_chan.ip_version       <= '0;
    in_chan.header_words     <= '0;
    in_chan.ip_total_len     <= '0;
    in_chan.flags_and_offset <= '0;
    in_chan.protocol_number  <= '0;
    in_chan.source_address   <= '0;
    in_chan.dest_address     <= '0;
    in_chan.clear_stats      <= 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // check order, length boundaries, protocols, fragments, address classes
    send_header(mk(0, 4, 5, 0, 0, PROTO_TCP, 32'h0A00_0001, 32'hE000_0001, 0));
    send_header(mk(19, 0, 0, 100, 0, PROTO_UDP, 32'h0A00_0002, 32'hE000_0002, 0));
    send_header(mk(19, 4, 5, 100, 0, PROTO_UDP, 32'h0A00_0002, 32'hE000_0002, 0));
    send_header(mk(20, 4, 5, 40, 0, PROTO_TCP, 32'h0A00_0001, 32'hE000_0001, 0));
    send_header(mk(65535, 0, 5, 40, 0, PROTO_TCP, 32'h0A00_0003, 32'h0A00_0004, 0));
    send_header(mk(40, 15, 0, 40, 0, PROTO_TCP, 32'h0A00_0003, 32'h0A00_0004, 0));
    send_header(mk(40, 4, 4, 40, 0, PROTO_TCP, 32'h0A00_0003, 32'h0A00_0004, 0));
    send_header(mk(20, 4, 6, 40, 0, PROTO_TCP, 32'h0A00_0003, 32'h0A00_0004, 0));
    send_header(mk(60, 4, 15, 1500, 0, PROTO_UDP, 32'hAC10_0001, 32'hEFFF_FFFF, 0));
    send_header(mk(100, 4, 5, 576, 16'h1FFF, PROTO_ICMP, 32'hAC1F_FFFF, 32'hC0A8_0001, 0));
    send_header(mk(20, 4, 5, 60, 16'h2000, 8'd0, 32'hAC0F_0001, 32'hAC20_0001, 0));
    send_header(mk(1500, 4, 5, 1000, 16'h4000, 8'd255, 32'hC0A9_0001, 32'hDFFF_FFFF, 0));
    send_header(mk(20, 4, 5, 40, 0, PROTO_TCP, 32'h0A00_0001, 32'hE000_0001, 0));
    send_header(mk(10, 4, 5, 40, 0, PROTO_TCP, 32'h0A00_0001, 32'hE000_0001, 1));
    send_header(mk(65535, 4, 15, 65535, 16'hFFFF, PROTO_TCP, 32'h0, 32'hFFFF_FFFF, 0));
    send_header(mk(20, 4, 5, 0, 0, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 0));
    send_header(mk(44, 4, 11, 20, 16'h0001, PROTO_ICMP, 32'h0AFF_FFFF, 32'hF000_0000, 1));
    send_header(mk(20, 4, 5, 65535, 0, PROTO_TCP, 32'hC0A8_FFFF, 32'hEF00_0000, 0));
    send_header(mk(20, 4, 5, 65535, 0, 8'd2, 32'hC0A8_FFFF, 32'hEF00_0000, 0));

    // phase 0 fills both tables with fresh addresses, no clears
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; hold_req = 1; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      n_items = (phase == 0) ? 300 : 200;
      for (int i = 0; i < n_items; i++) begin
        if (phase == 0) send_header(gen_header(95, 98, 1'b0));
        else send_header(gen_header(85, 40, 1'b1));
      end
    end
    in_chan.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/ihcs_pkg.sv
src/ihcs_in_if.sv
src/ihcs_out_if.sv
src/ihcs_ram.sv
src/ihcs_table.sv
src/ihcs_stats.sv
src/ipv4_header_check_and_stats_top.sv
verif/ihcs_report_checker.sv
verif/tb.sv
